// File: design/assert_macros.svh
// Assertion macros shared by the keypad code lock RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: the consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kcl_pkg.sv
// Types, codes and key tables for the keypad code lock.
// Used by keypad_code_lock_core; depends on nothing.
package kcl_pkg;

  localparam int MAX_DIGITS = 6;
  localparam int MIN_LEN    = 4;
  localparam int KEY_W      = 4;
  localparam int POS_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  localparam logic [KEY_W-1:0] KEY_A     = 4'd3;
  localparam logic [KEY_W-1:0] KEY_B     = 4'd7;
  localparam logic [3:0]       NO_DIGIT  = 4'd15;
  localparam logic [3:0]       COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    MODE_ENTRY  = 2'd0,
    MODE_OFFER  = 2'd1,
    MODE_LENGTH = 2'd2,
    MODE_NEW    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_DIGIT     = 4'd0,
    ST_CORRECT   = 4'd1,
    ST_WRONG     = 4'd2,
    ST_ALARM     = 4'd3,
    ST_IGNORED   = 4'd4,
    ST_CHG_YES   = 4'd5,
    ST_CHG_NO    = 4'd6,
    ST_LEN_SET   = 4'd7,
    ST_NEW_DIGIT = 4'd8,
    ST_NEW_DONE  = 4'd9
  } status_t;

  typedef struct packed {
    logic [1:0] key_row;
    logic [1:0] key_col;
  } key_in_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] key_char;
    logic [3:0] attempts;
    logic [3:0] code_len;
  } result_t;

  // ASCII of each key, layout 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
  function automatic logic [6:0] key_ascii(input logic [KEY_W-1:0] key);
    logic [6:0] c;
    unique case (key)
      4'd0:    c = 7'h31;
      4'd1:    c = 7'h32;
      4'd2:    c = 7'h33;
      4'd3:    c = 7'h41;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h42;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h38;
      4'd10:   c = 7'h39;
      4'd11:   c = 7'h43;
      4'd12:   c = 7'h2A;
      4'd13:   c = 7'h30;
      4'd14:   c = 7'h23;
      default: c = 7'h44;
    endcase
    return c;
  endfunction

  // Numeric value of digit keys; NO_DIGIT for letters, star and hash.
  function automatic logic [3:0] key_value(input logic [KEY_W-1:0] key);
    logic [3:0] v;
    unique case (key)
      4'd0:    v = 4'd1;
      4'd1:    v = 4'd2;
      4'd2:    v = 4'd3;
      4'd4:    v = 4'd4;
      4'd5:    v = 4'd5;
      4'd6:    v = 4'd6;
      4'd8:    v = 4'd7;
      4'd9:    v = 4'd8;
      4'd10:   v = 4'd9;
      4'd13:   v = 4'd0;
      default: v = NO_DIGIT;
    endcase
    return v;
  endfunction

endpackage

// File: design/keypad_code_lock_core.sv
// Keypad code lock core: key event input stage, code compare and mode logic,
// result register and APB-style register port. Depends on kcl_pkg.
`include "assert_macros.svh"

// One debounced key press (row and column of a 4x4 keypad) enters per
// transfer and yields exactly one result: a status code, the key's ASCII
// character, the wrong attempt count and the code length in force. A key can
// be taken every cycle while the consumer does not stall the result channel.
// Each key waits in the input register, and its result in the result
// register, before the result is offered on the result channel. The whole
// decision (an all-positions compare against the stored code plus the mode
// update) is one registered pass. The input stage stalls only while the
// result register holds a result that the consumer has not yet taken. The
// single register max_attempts sits at byte address 0 and should be written
// only while no key is in flight. After reset the code is 1 2 3 4.
module keypad_code_lock_core
  import kcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // key event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  key_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration register.
  logic [3:0] max_attempts_r;

  // Pipeline registers.
  logic    in_valid_r, in_valid_nxt;
  key_in_t in_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  // Lock state.
  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [3:0]       wc_r, wc_nxt;
  logic [KEY_W-1:0] entered_r [MAX_DIGITS];
  logic [KEY_W-1:0] stored_r  [MAX_DIGITS];

  // Per-key working signals.
  logic             in_xfer;
  logic             adv;
  logic [KEY_W-1:0] key;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pos_inc;
  logic [IDX_W-1:0] idx;
  logic [3:0]       wc_inc;
  logic [3:0]       kval;
  logic             same;
  logic             ent_we;
  logic             code_we;
  status_t          status;

  logic cfg_wr;
  logic cfg_hit;

  // The input register moves into the result register whenever the result
  // register is empty or its result is being taken in this cycle.
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    in_valid_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : in_valid_r);
    out_valid_nxt = adv ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);
  end

  // Register port: one register at address 0; other addresses read zero.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'b0) && (paddr[1:0] == 2'b00);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? {28'd0, max_attempts_r} : 32'd0;

  assign key     = {in_r.key_row, in_r.key_col};
  // The position never legally reaches MAX_DIGITS; wrap it defensively.
  assign pos_eff = (pos_r >= POS_W'(MAX_DIGITS)) ? '0 : pos_r;
  assign pos_inc = pos_eff + POS_W'(1);
  assign idx     = pos_eff[IDX_W-1:0];
  assign wc_inc  = (wc_r != COUNT_MAX) ? (wc_r + 4'd1) : wc_r;
  assign kval    = key_value(key);

  // Compare every active position at once; the key arriving now stands in
  // for the entry it is about to overwrite.
  always_comb begin
    same = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((POS_W'(i) < len_r) &&
          (((IDX_W'(i) == idx) ? key : entered_r[i]) != stored_r[i])) begin
        same = 1'b0;
      end
    end
  end

  // Mode sequencer and result formation.
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_eff;
    len_nxt  = len_r;
    wc_nxt   = wc_r;
    status   = ST_IGNORED;
    ent_we   = 1'b0;
    code_we  = 1'b0;
    unique case (mode_r)
      MODE_ENTRY: begin
        ent_we  = 1'b1;
        pos_nxt = pos_inc;
        status  = ST_DIGIT;
        if (pos_inc >= len_r) begin
          pos_nxt = '0;
          if (same) begin
            status   = ST_CORRECT;
            mode_nxt = MODE_OFFER;
          end else if (wc_inc >= max_attempts_r) begin
            status = ST_ALARM;
            wc_nxt = 4'd0;
          end else begin
            status = ST_WRONG;
            wc_nxt = wc_inc;
          end
        end
      end
      MODE_OFFER: begin
        if (key == KEY_A) begin
          status   = ST_CHG_YES;
          mode_nxt = MODE_LENGTH;
        end else if (key == KEY_B) begin
          status   = ST_CHG_NO;
          mode_nxt = MODE_ENTRY;
          pos_nxt  = '0;
        end
      end
      MODE_LENGTH: begin
        if ((kval >= 4'(MIN_LEN)) && (kval <= 4'(MAX_DIGITS))) begin
          len_nxt  = POS_W'(kval);
          pos_nxt  = '0;
          mode_nxt = MODE_NEW;
          status   = ST_LEN_SET;
        end
      end
      MODE_NEW: begin
        code_we = 1'b1;
        pos_nxt = pos_inc;
        status  = ST_NEW_DIGIT;
        if (pos_inc >= len_r) begin
          status   = ST_NEW_DONE;
          pos_nxt  = '0;
          mode_nxt = MODE_ENTRY;
        end
      end
      default: begin
        mode_nxt = MODE_ENTRY;
      end
    endcase
    out_nxt.status   = status;
    out_nxt.key_char = key_ascii(key);
    out_nxt.attempts = wc_nxt;
    out_nxt.code_len = 4'(len_nxt);
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      max_attempts_r <= 4'd3;
      mode_r         <= MODE_ENTRY;
      pos_r          <= '0;
      len_r          <= POS_W'(MIN_LEN);
      wc_r           <= 4'd0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        max_attempts_r <= pwdata[3:0];
      end
      if (adv) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        len_r  <= len_nxt;
        wc_r   <= wc_nxt;
      end
    end
  end

  // Stored code: reset to keys 1 2 3 4 (key codes 0 1 2 4), rest zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        stored_r[i] <= '0;
      end
      stored_r[0] <= 4'd0;
      stored_r[1] <= 4'd1;
      stored_r[2] <= 4'd2;
      stored_r[3] <= 4'd4;
    end else if (adv && code_we) begin
      stored_r[idx] <= key;
    end
  end

  // Payload registers; no reset needed. Entered keys are only read after
  // being written in the current round.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
    if (adv && ent_we) begin
      entered_r[idx] <= key;
    end
  end

  // Checks on the lock's own bookkeeping.
  `ASSERT_CLK(a_pos_below_len, pos_r < len_r, "position reached code length")
  `ASSERT_CLK(a_len_range, (len_r >= POS_W'(MIN_LEN)) && (len_r <= POS_W'(MAX_DIGITS)),
              "code length out of range")
  `ASSERT_CLK(a_pos_idle_modes,
              ((mode_r != MODE_OFFER) && (mode_r != MODE_LENGTH)) || (pos_r == '0),
              "position not cleared outside key collection")
  `ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "advanced key left no result")
  `ASSERT_NEXT(a_alarm_clears, adv && (status == ST_ALARM), wc_r == 4'd0,
               "alarm did not clear the attempt count")

endmodule

// File: bench/testbench.sv
// Self-checking bench for keypad_code_lock_core: key presses and max_attempts register writes.
// Keeps its own model of the lock and checks every result transfer against it.
// Depends on kcl_pkg and the keypad_code_lock_core RTL.
module testbench
  import kcl_pkg::*;
();

  // Key indexes (row*4+col) for the layout 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
  // The A and B keys come from the package.
  localparam logic [3:0] KEY_1    = 4'd0;
  localparam logic [3:0] KEY_2    = 4'd1;
  localparam logic [3:0] KEY_3    = 4'd2;
  localparam logic [3:0] KEY_4    = 4'd4;
  localparam logic [3:0] KEY_5    = 4'd5;
  localparam logic [3:0] KEY_6    = 4'd6;
  localparam logic [3:0] KEY_7    = 4'd8;
  localparam logic [3:0] KEY_8    = 4'd9;
  localparam logic [3:0] KEY_9    = 4'd10;
  localparam logic [3:0] KEY_C    = 4'd11;
  localparam logic [3:0] KEY_STAR = 4'd12;
  localparam logic [3:0] KEY_0    = 4'd13;
  localparam logic [3:0] KEY_HASH = 4'd14;
  localparam logic [3:0] KEY_D    = 4'd15;

  // The only register in the map lies at byte address 0.
  localparam logic [2:0] REG_MAX_ATTEMPTS = 3'd0;

  // Echo character and digit value of every key, indexed by key number.
  // A value of 15 marks keys that are not digits.
  localparam logic [0:15][7:0] KEY_CHARS = "123A456B789C*0#D";
  localparam logic [0:15][3:0] KEY_DIGITS = {
    4'd1, 4'd2, 4'd3, 4'd15,
    4'd4, 4'd5, 4'd6, 4'd15,
    4'd7, 4'd8, 4'd9, 4'd15,
    4'd15, 4'd0, 4'd15, 4'd15
  };

  // All block inputs hold known values from time zero on.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  key_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  keypad_code_lock_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Our own copy of the lock state. It advances once per accepted key
  // transfer, in transfer order, so it always describes the block as it will
  // be after all keys sent so far have been processed.
  mode_t      lock_mode;
  logic [3:0] typed_keys [MAX_DIGITS];
  logic [3:0] code_keys [MAX_DIGITS];
  int         entry_pos;
  int         code_length;
  logic [3:0] wrong_cnt;
  logic [3:0] attempt_limit;

  // Results still owed by the block, oldest first.
  result_t pending_results [$];
  result_t due_result;
  status_t last_status;

  // Idle percentages of the key sender and of the result receiver.
  int tx_idle = 36;
  int rx_idle = 53;
  int failures = 0;

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [6:0] want,
                             input logic [6:0] got);
    if (got !== want)
      log_failure($sformatf("%s expected %0d, got %0d", field, want, got));
  endtask

  task automatic reset_lock_model();
    lock_mode = MODE_ENTRY;
    entry_pos = 0;
    code_length = MIN_LEN;
    wrong_cnt = '0;
    attempt_limit = 4'd3;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      typed_keys[i] = '0;
      code_keys[i] = '0;
    end
    // After reset the code is 1 2 3 4.
    code_keys[0] = KEY_1;
    code_keys[1] = KEY_2;
    code_keys[2] = KEY_3;
    code_keys[3] = KEY_4;
  endtask

  // Applies one key press to the model and returns the result it must cause.
  function automatic result_t next_lock_result(input logic [3:0] key);
    result_t    r;
    logic [3:0] digit;
    logic       same;
    r = '0;
    r.status = ST_IGNORED;
    digit = KEY_DIGITS[key];
    if (entry_pos >= MAX_DIGITS) entry_pos = 0;
    case (lock_mode)
      MODE_ENTRY: begin
        typed_keys[entry_pos] = key;
        entry_pos++;
        r.status = ST_DIGIT;
        if (entry_pos >= code_length) begin
          // Only the positions typed in this round take part in the compare.
          same = 1'b1;
          for (int i = 0; i < code_length; i++)
            if (typed_keys[i] != code_keys[i]) same = 1'b0;
          entry_pos = 0;
          if (same) begin
            // A correct code leaves the wrong count alone.
            r.status = ST_CORRECT;
            lock_mode = MODE_OFFER;
          end else begin
            if (wrong_cnt < COUNT_MAX) wrong_cnt++;
            // Compared with >= so that a lowered or zero limit fires at once.
            if (wrong_cnt >= attempt_limit) begin
              r.status = ST_ALARM;
              wrong_cnt = '0;
            end else begin
              r.status = ST_WRONG;
            end
          end
        end
      end
      MODE_OFFER: begin
        if (key == KEY_A) begin
          r.status = ST_CHG_YES;
          lock_mode = MODE_LENGTH;
        end else if (key == KEY_B) begin
          r.status = ST_CHG_NO;
          lock_mode = MODE_ENTRY;
          entry_pos = 0;
        end
      end
      MODE_LENGTH: begin
        if (digit >= MIN_LEN && digit <= MAX_DIGITS) begin
          code_length = digit;
          entry_pos = 0;
          lock_mode = MODE_NEW;
          r.status = ST_LEN_SET;
        end
      end
      default: begin
        code_keys[entry_pos] = key;
        entry_pos++;
        r.status = ST_NEW_DIGIT;
        if (entry_pos >= code_length) begin
          r.status = ST_NEW_DONE;
          entry_pos = 0;
          lock_mode = MODE_ENTRY;
        end
      end
    endcase
    r.key_char = KEY_CHARS[key][6:0];
    r.attempts = wrong_cnt;
    r.code_len = 4'(code_length);
    return r;
  endfunction

  // Sends one key press. A random gap may come first; valid then stays high
  // until the transfer happens. The caller may send the next key in the same
  // time step, which keeps valid high with no bubble.
  task automatic send_key(input logic [3:0] key);
    int gap;
    gap = 0;
    while (tx_idle > 0 && $urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= key_in_t'(key);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_result = next_lock_result(key);
    last_status = due_result.status;
    pending_results.push_back(due_result);
  endtask

  // Stops sending and waits until every owed result has been taken, then lets
  // the two-stage pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register reads and writes each start on a fresh clock edge, so a psel
  // drop at the end of one access never meets a psel rise in the same step.
  task automatic read_limit(output logic [3:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_MAX_ATTEMPTS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    value = prdata[3:0];
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [3:0] value);
    logic [3:0] readback;
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MAX_ATTEMPTS;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    attempt_limit = value;
    read_limit(readback);
    check_field("max_attempts readback", attempt_limit, readback);
  endtask

  // Picks a key that mostly follows a legal path through the lock: the right
  // code, A or B on the offer, a valid length, with some noise mixed in.
  function automatic logic [3:0] choose_key();
    logic [3:0] k;
    int         roll;
    k = 4'($urandom_range(15));
    roll = $urandom_range(99);
    case (lock_mode)
      MODE_ENTRY:  if (roll < 85) k = code_keys[entry_pos];
      MODE_OFFER:  if (roll < 45) k = KEY_A; else if (roll < 80) k = KEY_B;
      MODE_LENGTH: if (roll < 75) k = KEY_4 + 4'($urandom_range(2));
      default:     ;
    endcase
    return k;
  endfunction

  task automatic test_register_reset();
    logic [3:0] readback;
    read_limit(readback);
    check_field("max_attempts after reset", attempt_limit, readback);
  endtask

  // Every key once in entry mode: four wrong codes that walk the count up,
  // and every row and column value on the input.
  task automatic test_every_key();
    set_limit(4'd15);
    for (int k = 0; k < 16; k++) send_key(4'(k));
  endtask

  // Limit lowered below the current count, then a zero limit: in both cases
  // the very next wrong code fires the alarm.
  task automatic test_limit_changes();
    set_limit(4'd2);
    repeat (4) send_key(KEY_0);
    set_limit(4'd0);
    repeat (4) send_key(KEY_0);
    set_limit(4'd3);
  endtask

  task automatic test_open_and_decline();
    send_key(KEY_1);
    send_key(KEY_2);
    send_key(KEY_3);
    send_key(KEY_4);
    send_key(KEY_STAR);
    send_key(KEY_B);
  endtask

  // Opens the lock, accepts a change, tries keys that are no valid length,
  // picks the longest code, stores it and then opens with it.
  task automatic test_change_code();
    logic [3:0] fresh [6];
    fresh = '{KEY_9, KEY_HASH, KEY_STAR, KEY_C, KEY_A, KEY_0};
    send_key(KEY_1);
    send_key(KEY_2);
    send_key(KEY_3);
    send_key(KEY_4);
    send_key(KEY_A);
    send_key(KEY_D);
    send_key(KEY_3);
    send_key(KEY_7);
    send_key(KEY_6);
    foreach (fresh[i]) send_key(fresh[i]);
    foreach (fresh[i]) send_key(fresh[i]);
    send_key(KEY_B);
  endtask

  // Random keys under one idle pattern and one limit. Ignored keys do not
  // count toward the number of keys asked for.
  task automatic test_random_phase(input int tx_pct, input int rx_pct,
                                   input logic [3:0] limit, input int keys);
    int taken;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    set_limit(limit);
    taken = 0;
    while (taken < keys) begin
      send_key(choose_key());
      if (last_status != ST_IGNORED) taken++;
    end
  endtask

  // The receiver stalls at random according to the current pattern.
  always @(posedge clk)
    out_stall <= (rx_idle > 0) && ($urandom_range(99) < rx_idle);

  // Each result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_failure($sformatf("result with nothing owed: %h", out_data));
      end else begin
        due_result = pending_results.pop_front();
        check_field("status", due_result.status, out_data.status);
        check_field("key_char", due_result.key_char, out_data.key_char);
        check_field("attempts", due_result.attempts, out_data.attempts);
        check_field("code_len", due_result.code_len, out_data.code_len);
      end
    end
  end

  initial begin
    reset_lock_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_register_reset();
    test_every_key();
    test_limit_changes();
    test_open_and_decline();
    test_change_code();
    test_random_phase(36, 53, 4'd1, 115);
    test_random_phase(53, 36, 4'd15, 115);
    test_random_phase(0, 0, 4'($urandom_range(1, 15)), 115);
    wait_idle();
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/kcl_pkg.sv
design/keypad_code_lock_core.sv
bench/testbench.sv
